// ===== rtl/swps_pkg.sv =====
// Shared types and constants for the sliding window packet sender.
// No dependencies; imported by the top level and the testbench.
package swps_pkg;

  localparam int PKT_BYTES_DEF    = 128;
  localparam int RING_PACKETS_DEF = 64;
  localparam int MAX_RESULTS      = 32;
  localparam int ACK_RESENDS      = 2;

  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_ACK  = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic [1:0] REG_SEND_WINDOW   = 2'd0;
  localparam logic [1:0] REG_FIRST_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_RETRY_TIMEOUT = 2'd2;

  localparam logic [1:0] RSN_NEW     = 2'd0;
  localparam logic [1:0] RSN_ACK     = 2'd1;
  localparam logic [1:0] RSN_TIMEOUT = 2'd2;
  localparam logic [1:0] RSN_DROP    = 2'd3;

  localparam logic [6:0]  SEND_WINDOW_RST   = 7'd10;
  localparam logic [15:0] FIRST_TIMEOUT_RST = 16'd200;
  localparam logic [15:0] RETRY_TIMEOUT_RST = 16'd300;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIN_FILL,
    ST_FIN_HDR,
    ST_DROP,
    ST_EM_RD,
    ST_EM_WR
  } state_t;

endpackage

// ===== rtl/swps_ring.sv =====
// Packet ring storage: one write port, one registered read port.
// Depends on nothing beyond its parameters.
module swps_ring #(
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [63:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [63:0]   rdata
);

  logic [63:0] mem [0:(1<<AW)-1];
  logic [63:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/sliding_window_packet_sender.sv =====
// Top level of the sliding window packet sender; uses swps_pkg and swps_ring.
// Holds the packet builder, window and timer control and the output register.
//
// A message byte or tick is taken in ST_IDLE; one that causes results moves on.
// Closing a packet writes each remaining packet word in ST_FIN_FILL, then
// leaves the zero fill and writes the header in ST_FIN_HDR; each emitted word
// then takes a ring read (ST_EM_RD) and an output load (ST_EM_WR), which waits
// while the output register is full; a dropped packet emits its drop word from
// ST_DROP; an ack re-send emits up to two packets in turn. No input request is
// taken while a packet is being closed or emitted. The ring needs no clearing
// pass: only stored packets are read.
module sliding_window_packet_sender #(
  parameter int PKT_BYTES    = swps_pkg::PKT_BYTES_DEF,
  parameter int RING_PACKETS = swps_pkg::RING_PACKETS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_msg_byte,
  input  logic        in_msg_end,
  input  logic [31:0] in_ack_seq,
  input  logic [31:0] in_ack_seq_copy,
  input  logic [7:0]  in_ack_flag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_pkt_word,
  output logic [3:0]  out_word_index,
  output logic [31:0] out_pkt_seq,
  output logic [1:0]  out_send_reason,
  output logic        out_last_word,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import swps_pkg::*;

  localparam int WORDS       = PKT_BYTES / 8;
  localparam int PAYLOAD_MAX = WORDS * 8 - 8;
  localparam int WB          = $clog2(WORDS);
  localparam int SB          = $clog2(RING_PACKETS);
  localparam int FB          = $clog2(PAYLOAD_MAX + 1);
  localparam int AW          = SB + WB;
  localparam int LIMIT       = (ACK_RESENDS > MAX_RESULTS / WORDS) ?
                               MAX_RESULTS / WORDS : ACK_RESENDS;

  state_t state_r, state_nxt;

  logic [6:0]  send_window_r;
  logic [15:0] first_to_r, retry_to_r;

  logic [31:0]   next_seq_r, next_seq_nxt, base_seq_r, base_seq_nxt;
  logic [SB-1:0] next_slot_r, next_slot_nxt, base_slot_r, base_slot_nxt;
  logic [FB-1:0] fill_r, fill_nxt;
  logic [63:0]   asm_r, asm_nxt, fold_r, fold_nxt;
  logic          blocked_r, blocked_nxt;
  logic [15:0]   tcount_r, tcount_nxt;
  logic          trun_r, trun_nxt;
  logic [WB:0]   fw_r, fw_nxt;

  logic [31:0]   em_seq_r, em_seq_nxt;
  logic [SB-1:0] em_slot_r, em_slot_nxt;
  logic [1:0]    em_rsn_r, em_rsn_nxt;
  logic [WB-1:0] em_w_r, em_w_nxt;
  logic          em_more_r, em_more_nxt;

  logic        ov_r, ov_nxt, ov_last_r, ov_last_nxt;
  logic [63:0] ov_word_r, ov_word_nxt;
  logic [3:0]  ov_idx_r, ov_idx_nxt;
  logic [31:0] ov_seq_r, ov_seq_nxt;
  logic [1:0]  ov_rsn_r, ov_rsn_nxt;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [63:0]   mem_wdata, mem_rdata;

  swps_ring #(.AW(AW)) u_ring (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  function automatic logic [SB-1:0] slot_inc(input logic [SB-1:0] s);
    logic [SB:0] t;
    t = {1'b0, s} + 1'b1;
    if (t == (SB+1)'(RING_PACKETS)) begin
      t = '0;
    end
    return t[SB-1:0];
  endfunction

  // combinational helpers
  logic          in_acc, can_load, ring_full;
  logic [FB:0]   pos;
  logic [FB-1:0] fill_inc;
  logic [63:0]   asm_or, hdr, cks;
  logic [31:0]   ack_off, ack_rem, seq_inc;
  logic [SB:0]   bslot_sum;
  logic [5:0]    w_ext;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign can_load  = !ov_r || !out_stall;
  assign ring_full = (next_seq_r - base_seq_r) >= 32'(RING_PACKETS);
  assign pos       = (FB+1)'(8) + {1'b0, fill_r};
  assign fill_inc  = fill_r + 1'b1;
  assign asm_or    = asm_r | (64'(in_msg_byte) << {pos[2:0], 3'b000});
  assign ack_off   = in_ack_seq - base_seq_r;
  assign ack_rem   = next_seq_r - in_ack_seq - 32'd1;
  assign bslot_sum = {1'b0, base_slot_r} + (SB+1)'(ack_off) + 1'b1;
  assign seq_inc   = next_seq_r + 32'd1;
  assign w_ext     = 6'(em_w_r);

  always_comb begin
    hdr = {next_seq_r, 24'd0, 8'(fill_r)};
    cks = fold_r ^ hdr;
    cks = cks ^ (cks >> 32);
    cks = cks ^ (cks >> 16);
    cks = cks ^ (cks >> 8);
    hdr[15:8] = cks[7:0];
  end

  always_comb begin
    state_nxt     = state_r;
    next_seq_nxt  = next_seq_r;
    base_seq_nxt  = base_seq_r;
    next_slot_nxt = next_slot_r;
    base_slot_nxt = base_slot_r;
    fill_nxt      = fill_r;
    asm_nxt       = asm_r;
    fold_nxt      = fold_r;
    blocked_nxt   = blocked_r;
    tcount_nxt    = tcount_r;
    trun_nxt      = trun_r;
    fw_nxt        = fw_r;
    em_seq_nxt    = em_seq_r;
    em_slot_nxt   = em_slot_r;
    em_rsn_nxt    = em_rsn_r;
    em_w_nxt      = em_w_r;
    em_more_nxt   = em_more_r;
    ov_nxt        = ov_r && out_stall;
    ov_word_nxt   = ov_word_r;
    ov_idx_nxt    = ov_idx_r;
    ov_seq_nxt    = ov_seq_r;
    ov_rsn_nxt    = ov_rsn_r;
    ov_last_nxt   = ov_last_r;
    mem_we        = 1'b0;
    mem_waddr     = {next_slot_r, WB'(pos >> 3)};
    mem_wdata     = asm_or;
    mem_re        = 1'b0;
    mem_raddr     = {em_slot_r, em_w_r};

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            CMD_BYTE: begin
              asm_nxt  = asm_or;
              fill_nxt = fill_inc;
              if (pos[2:0] == 3'd7) begin
                if (ring_full) begin
                  blocked_nxt = 1'b1;
                end else begin
                  mem_we = 1'b1;
                end
                fold_nxt = fold_r ^ asm_or;
                asm_nxt  = '0;
              end
              if (fill_inc >= FB'(PAYLOAD_MAX) || in_msg_end) begin
                fw_nxt    = (WB+1)'(((FB+1)'(8) + {1'b0, fill_inc}) >> 3);
                state_nxt = ST_FIN_FILL;
              end
              if (in_msg_end && !trun_r) begin
                tcount_nxt = first_to_r;
                trun_nxt   = 1'b1;
              end
            end
            CMD_ACK: begin
              if (in_ack_seq == in_ack_seq_copy && in_ack_flag != 8'd0 &&
                  ack_off < (next_seq_r - base_seq_r)) begin
                base_seq_nxt  = in_ack_seq + 32'd1;
                base_slot_nxt = (bslot_sum >= (SB+1)'(RING_PACKETS)) ?
                                SB'(bslot_sum - (SB+1)'(RING_PACKETS)) :
                                bslot_sum[SB-1:0];
                tcount_nxt    = retry_to_r;
                trun_nxt      = 1'b1;
                em_seq_nxt    = in_ack_seq + 32'd1;
                em_slot_nxt   = base_slot_nxt;
                em_rsn_nxt    = RSN_ACK;
                em_w_nxt      = '0;
                em_more_nxt   = (LIMIT > 1) && (ack_rem > 32'd1);
                if (ack_rem != 32'd0) begin
                  state_nxt = ST_EM_RD;
                end
              end
            end
            CMD_TICK: begin
              if (trun_r) begin
                if (tcount_r <= 16'd1) begin
                  if (base_seq_r == next_seq_r) begin
                    trun_nxt   = 1'b0;
                    tcount_nxt = '0;
                  end else begin
                    tcount_nxt  = retry_to_r;
                    em_seq_nxt  = base_seq_r;
                    em_slot_nxt = base_slot_r;
                    em_rsn_nxt  = RSN_TIMEOUT;
                    em_w_nxt    = '0;
                    em_more_nxt = 1'b0;
                    state_nxt   = ST_EM_RD;
                  end
                end else begin
                  tcount_nxt = tcount_r - 16'd1;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_FIN_FILL: begin
        // partial word first, then zero the rest of the packet
        if (fw_r < (WB+1)'(WORDS)) begin
          mem_waddr = {next_slot_r, fw_r[WB-1:0]};
          mem_wdata = asm_r;
          if (ring_full) begin
            blocked_nxt = 1'b1;
          end else begin
            mem_we = 1'b1;
          end
          fold_nxt = fold_r ^ asm_r;
          asm_nxt  = '0;
          fw_nxt   = fw_r + 1'b1;
        end else begin
          state_nxt = ST_FIN_HDR;
        end
      end
      ST_FIN_HDR: begin
        mem_waddr   = {next_slot_r, WB'(0)};
        mem_wdata   = hdr;
        mem_we      = !ring_full;
        fill_nxt    = '0;
        asm_nxt     = '0;
        fold_nxt    = '0;
        blocked_nxt = 1'b0;
        if (blocked_r || ring_full) begin
          state_nxt = ST_DROP;
        end else begin
          next_seq_nxt  = seq_inc;
          next_slot_nxt = slot_inc(next_slot_r);
          em_seq_nxt    = next_seq_r;
          em_slot_nxt   = next_slot_r;
          em_rsn_nxt    = RSN_NEW;
          em_w_nxt      = '0;
          em_more_nxt   = 1'b0;
          state_nxt     = ((seq_inc - base_seq_r) < 32'(send_window_r)) ?
                          ST_EM_RD : ST_IDLE;
        end
      end
      ST_DROP: begin
        if (can_load) begin
          ov_nxt      = 1'b1;
          ov_word_nxt = '0;
          ov_idx_nxt  = '0;
          ov_seq_nxt  = next_seq_r;
          ov_rsn_nxt  = RSN_DROP;
          ov_last_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      ST_EM_RD: begin
        mem_re    = 1'b1;
        state_nxt = ST_EM_WR;
      end
      ST_EM_WR: begin
        // hold the read word until the output register frees up
        if (can_load) begin
          ov_nxt      = 1'b1;
          ov_word_nxt = mem_rdata;
          ov_idx_nxt  = w_ext[3:0];
          ov_seq_nxt  = em_seq_r;
          ov_rsn_nxt  = em_rsn_r;
          ov_last_nxt = (em_w_r == WB'(WORDS - 1)) && !em_more_r;
          state_nxt   = ST_EM_RD;
          if (em_w_r == WB'(WORDS - 1)) begin
            em_w_nxt = '0;
            if (em_more_r) begin
              em_more_nxt = 1'b0;
              em_seq_nxt  = em_seq_r + 32'd1;
              em_slot_nxt = slot_inc(em_slot_r);
            end else begin
              state_nxt = ST_IDLE;
            end
          end else begin
            em_w_nxt = em_w_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      send_window_r <= SEND_WINDOW_RST;
      first_to_r    <= FIRST_TIMEOUT_RST;
      retry_to_r    <= RETRY_TIMEOUT_RST;
      next_seq_r    <= '0;
      base_seq_r    <= '0;
      next_slot_r   <= '0;
      base_slot_r   <= '0;
      fill_r        <= '0;
      asm_r         <= '0;
      fold_r        <= '0;
      blocked_r     <= 1'b0;
      tcount_r      <= '0;
      trun_r        <= 1'b0;
      ov_r          <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      next_seq_r  <= next_seq_nxt;
      base_seq_r  <= base_seq_nxt;
      next_slot_r <= next_slot_nxt;
      base_slot_r <= base_slot_nxt;
      fill_r      <= fill_nxt;
      asm_r       <= asm_nxt;
      fold_r      <= fold_nxt;
      blocked_r   <= blocked_nxt;
      tcount_r    <= tcount_nxt;
      trun_r      <= trun_nxt;
      ov_r        <= ov_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_SEND_WINDOW:   send_window_r <= cfg_wdata[6:0];
          REG_FIRST_TIMEOUT: first_to_r    <= cfg_wdata;
          REG_RETRY_TIMEOUT: retry_to_r    <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    fw_r      <= fw_nxt;
    em_seq_r  <= em_seq_nxt;
    em_slot_r <= em_slot_nxt;
    em_rsn_r  <= em_rsn_nxt;
    em_w_r    <= em_w_nxt;
    em_more_r <= em_more_nxt;
    ov_word_r <= ov_word_nxt;
    ov_idx_r  <= ov_idx_nxt;
    ov_seq_r  <= ov_seq_nxt;
    ov_rsn_r  <= ov_rsn_nxt;
    ov_last_r <= ov_last_nxt;
  end

  assign out_valid       = ov_r;
  assign out_pkt_word    = ov_word_r;
  assign out_word_index  = ov_idx_r;
  assign out_pkt_seq     = ov_seq_r;
  assign out_send_reason = ov_rsn_r;
  assign out_last_word   = ov_last_r;

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for sliding_window_packet_sender: drives message bytes, acks and ticks,
// predicts the packet words from its own copy of the sender state and checks them.
// Depends on swps_pkg and the RTL top level only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import swps_pkg::*;

  localparam int WORDS = 16;
  localparam int PAYLOAD_MAX = 120;
  localparam int RING = 64;

  typedef struct {
    logic [63:0] word;
    logic [3:0]  idx;
    logic [31:0] seq;
    logic [1:0]  rsn;
    logic        last;
  } pkt_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_cmd = CMD_TICK;
  logic [7:0] in_msg_byte = '0;
  logic in_msg_end = 1'b0;
  logic [31:0] in_ack_seq = '0;
  logic [31:0] in_ack_seq_copy = '0;
  logic [7:0] in_ack_flag = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [63:0] out_pkt_word;
  logic [3:0] out_word_index;
  logic [31:0] out_pkt_seq;
  logic [1:0] out_send_reason;
  logic out_last_word;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = REG_SEND_WINDOW;
  logic [15:0] cfg_wdata = '0;

  sliding_window_packet_sender dut (.*);

  always #1 clk = ~clk;

  // sender model state
  logic [63:0] ring_mem [0:RING*WORDS-1];
  logic [31:0] nseq, bseq;
  int          fill;
  logic [63:0] asm_word, fold_acc;
  logic [15:0] tmr_cnt;
  logic        tmr_run, blocked;
  logic [6:0]  win;
  logic [15:0] first_to, retry_to;

  pkt_word_t sent_q[$];
  int errors = 0;
  int idle_pct = 23;
  longint cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) out_stall <= ($urandom_range(99) < idle_pct);

  always @(posedge clk) begin
    pkt_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (sent_q.size() == 0) begin
        $display("%0t unexpected word %h seq %0d", $time, out_pkt_word, out_pkt_seq);
        errors++;
      end else begin
        e = sent_q.pop_front();
        if (e.word !== out_pkt_word || e.idx !== out_word_index || e.seq !== out_pkt_seq ||
            e.rsn !== out_send_reason || e.last !== out_last_word) begin
          $display("%0t mismatch exp %h/%0d/%0d/%0d/%0b act %h/%0d/%0d/%0d/%0b", $time,
                   e.word, e.idx, e.seq, e.rsn, e.last, out_pkt_word, out_word_index,
                   out_pkt_seq, out_send_reason, out_last_word);
          errors++;
        end
      end
    end
  end

  function automatic bit ring_full();
    return (nseq - bseq) >= RING;
  endfunction

  function automatic void push_word(logic [63:0] w, int idx, logic [31:0] s, logic [1:0] r);
    pkt_word_t e;
    e.word = w; e.idx = idx[3:0]; e.seq = s; e.rsn = r; e.last = 1'b0;
    sent_q.insert(sent_q.size(), e);
  endfunction

  function automatic void store_word(int w, logic [63:0] v);
    if (ring_full()) blocked = 1'b1;
    else if (w < WORDS) ring_mem[(nseq % RING) * WORDS + w] = v;
  endfunction

  function automatic void emit_pkt(logic [31:0] s, logic [1:0] r);
    for (int w = 0; w < WORDS; w++) push_word(ring_mem[(s % RING) * WORDS + w], w, s, r);
  endfunction

  function automatic void close_pkt();
    int pos;
    int w;
    logic [63:0] hdr, c;
    pos = 8 + fill;
    w = pos >> 3;
    if ((pos & 7) != 0) begin
      store_word(w, asm_word);
      fold_acc ^= asm_word;
      w++;
    end
    for (; w < WORDS; w++) store_word(w, 64'd0);
    hdr = {nseq, 24'd0, fill[7:0]};
    c = fold_acc ^ hdr;
    c ^= c >> 32;
    c ^= c >> 16;
    c ^= c >> 8;
    hdr |= {48'd0, c[7:0], 8'd0};
    store_word(0, hdr);
    if (blocked || ring_full()) begin
      push_word(64'd0, 0, nseq, RSN_DROP);
    end else begin
      nseq++;
      if ((nseq - bseq) < win) emit_pkt(nseq - 1, RSN_NEW);
    end
    fill = 0; asm_word = '0; fold_acc = '0; blocked = 1'b0;
  endfunction

  function automatic void predict(logic [1:0] cmd, logic [7:0] b, logic e, logic [31:0] a,
                                  logic [31:0] ac, logic [7:0] f);
    int prev_len;
    int pos;
    logic [31:0] s;
    prev_len = sent_q.size();
    if (cmd == CMD_BYTE) begin
      pos = 8 + fill;
      asm_word |= 64'(b) << (8 * (pos & 7));
      fill++;
      if ((pos & 7) == 7) begin
        store_word(pos >> 3, asm_word);
        fold_acc ^= asm_word;
        asm_word = '0;
      end
      if (fill >= PAYLOAD_MAX || e) close_pkt();
      if (e && !tmr_run) begin
        tmr_cnt = first_to;
        tmr_run = 1'b1;
      end
    end else if (cmd == CMD_ACK) begin
      if (a == ac && f != 0 && (a - bseq) < (nseq - bseq)) begin
        bseq = a + 1;
        for (int k = 0; k < ACK_RESENDS; k++) begin
          s = bseq + k;
          if ((s - bseq) >= (nseq - bseq)) break;
          emit_pkt(s, RSN_ACK);
        end
        tmr_cnt = retry_to;
        tmr_run = 1'b1;
      end
    end else if (cmd == CMD_TICK) begin
      if (tmr_run) begin
        if (tmr_cnt <= 1) begin
          if (bseq == nseq) begin
            tmr_run = 1'b0;
            tmr_cnt = '0;
          end else begin
            emit_pkt(bseq, RSN_TIMEOUT);
            tmr_cnt = retry_to;
          end
        end else begin
          tmr_cnt--;
        end
      end
    end
    if (sent_q.size() > prev_len) sent_q[$].last = 1'b1;
  endfunction

  // hold the request until taken, idling beforehand at random
  task automatic send_req(logic [1:0] cmd, logic [7:0] b, logic e, logic [31:0] a,
                          logic [31:0] ac, logic [7:0] f);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_cmd <= cmd; in_msg_byte <= b; in_msg_end <= e;
    in_ack_seq <= a; in_ack_seq_copy <= ac; in_ack_flag <= f;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict(cmd, b, e, a, ac, f);
  endtask

  task automatic send_msg(int len);
    for (int i = 0; i < len; i++)
      send_req(CMD_BYTE, 8'($urandom_range(255)), i == len - 1, $urandom, $urandom,
               8'($urandom));
  endtask

  task automatic send_ack(logic [31:0] a);
    send_req(CMD_ACK, 8'($urandom), 1'($urandom), a, a, 8'($urandom_range(255, 1)));
  endtask

  task automatic send_tick();
    send_req(CMD_TICK, 8'($urandom), 1'($urandom), $urandom, $urandom, 8'($urandom));
  endtask

  // drain: all words back, then let any silent packet close finish
  task automatic settle();
    in_valid <= 1'b0;
    while (sent_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] v);
    cfg_wr_en <= 1'b1; cfg_index <= idx; cfg_wdata <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_SEND_WINDOW:   win = v[6:0];
      REG_FIRST_TIMEOUT: first_to = v;
      REG_RETRY_TIMEOUT: retry_to = v;
      default: ;
    endcase
  endtask

  task automatic test_directed();
    write_reg(REG_SEND_WINDOW, 16'd4);
    write_reg(REG_FIRST_TIMEOUT, 16'd2);
    write_reg(REG_RETRY_TIMEOUT, 16'd1);
    send_req(CMD_BYTE, 8'hFF, 1'b1, '0, '0, '0);
    send_req(CMD_BYTE, 8'h00, 1'b1, '1, '1, '1);
    send_msg(9);
    send_req(CMD_ACK, '0, '0, 32'd0, 32'd1, 8'hFF);   // copies disagree
    send_req(CMD_ACK, '0, '0, 32'd0, 32'd0, 8'h00);   // negative ack
    send_ack(32'hFFFF_FFFF);                          // beyond next sequence
    send_req(CMD_ACK, '0, '0, 32'd0, 32'd0, 8'h80);   // valid, re-sends two
    send_tick();                                      // timeout re-send of base
    send_tick();
    send_req(2'd3, '1, '1, '1, '1, '1);               // unknown command
    send_ack(nseq - 1);                               // all acked
    send_tick();                                      // expiry stops timer
    send_tick();
    settle();
  endtask

  task automatic test_overflow();
    write_reg(REG_SEND_WINDOW, 16'd1);
    for (int i = 0; i < RING + 2; i++) send_msg(1);
    send_msg(12);                                     // dropped mid-fill
    send_ack(bseq);
    send_msg(3);
    send_ack(nseq - 1);
    settle();
  endtask

  task automatic test_random(int items);
    int n;
    int r;
    n = 0;
    while (n < items) begin
      r = $urandom_range(99);
      if (r < 45) begin
        r = $urandom_range(99);
        r = (r < 5) ? PAYLOAD_MAX + $urandom_range(10) : $urandom_range(12, 1);
        send_msg(r);
        n += r;
      end else if (r < 70) begin
        if (nseq != bseq && $urandom_range(3) != 0)
          send_ack(bseq + $urandom_range(nseq - bseq - 1));
        else
          send_req(CMD_ACK, 8'($urandom), 1'($urandom), $urandom, $urandom, 8'($urandom));
        n++;
      end else if (r < 97) begin
        send_tick();
        n++;
      end else begin
        send_req(2'd3, 8'($urandom), 1'($urandom), $urandom, $urandom, 8'($urandom));
        n++;
      end
    end
    settle();
  endtask

  task automatic test_settings();
    write_reg(REG_SEND_WINDOW, 16'd64);
    write_reg(REG_FIRST_TIMEOUT, 16'd3);
    write_reg(REG_RETRY_TIMEOUT, 16'd5);
    test_random(5);
    write_reg(REG_SEND_WINDOW, 16'($urandom_range(63, 2)));
    write_reg(REG_FIRST_TIMEOUT, 16'd1);
    write_reg(REG_RETRY_TIMEOUT, 16'($urandom_range(8, 1)));
    test_random(5);
    idle_pct = 0;                                     // no idling in this stretch
    write_reg(REG_SEND_WINDOW, 16'd1);
    write_reg(REG_FIRST_TIMEOUT, 16'd65535);
    write_reg(REG_RETRY_TIMEOUT, 16'd65535);
    test_random(15);
    idle_pct = 23;
    write_reg(REG_SEND_WINDOW, 16'd10);
    write_reg(REG_FIRST_TIMEOUT, 16'd2);
    write_reg(REG_RETRY_TIMEOUT, 16'd3);
    test_random(5);
  endtask

  initial begin
    nseq = '0; bseq = '0; fill = 0; asm_word = '0; fold_acc = '0;
    tmr_cnt = '0; tmr_run = 1'b0; blocked = 1'b0;
    win = SEND_WINDOW_RST; first_to = FIRST_TIMEOUT_RST; retry_to = RETRY_TIMEOUT_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_settings();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
